[src/display_mode_topk_ranker_core_assert.svh]
// Assertion macros for the display mode ranker.
// Included by the RTL files that check their own logic; needs clk_i and rst_ni in scope.
`ifndef DISPLAY_MODE_TOPK_RANKER_CORE_ASSERT_SVH
`define DISPLAY_MODE_TOPK_RANKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define DMTR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("dmtr assertion failed");
// Check a property on every clock edge, reset included
`define DMTR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("dmtr assertion failed");
`else
`define DMTR_ASSERT(lbl, prop)
`define DMTR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[src/dmtr_pkg.sv]
// Shared types and constants of the display mode ranker.
// No dependencies; imported by the interfaces and all modules except dmtr_ram.
package dmtr_pkg;

  localparam int DIM_W   = 14;
  localparam int DEPTH_W = 6;
  localparam int RANK_W  = 3;
  localparam int AREA_W  = 2 * DIM_W;
  localparam int PROD_W  = AREA_W + DIM_W;
  localparam int APB_AW  = 5;
  localparam int APB_DW  = 32;

  localparam logic [DIM_W-1:0]   RST_MIN_WIDTH   = 14'd640;
  localparam logic [DIM_W-1:0]   RST_MIN_HEIGHT  = 14'd480;
  localparam logic [DIM_W-1:0]   RST_DESK_WIDTH  = 14'd1920;
  localparam logic [DIM_W-1:0]   RST_DESK_HEIGHT = 14'd1080;
  localparam logic [DEPTH_W-1:0] RST_DESK_DEPTH  = 6'd32;

  typedef enum logic [2:0] {
    REG_MIN_WIDTH   = 3'd0,
    REG_MIN_HEIGHT  = 3'd1,
    REG_DESK_WIDTH  = 3'd2,
    REG_DESK_HEIGHT = 3'd3,
    REG_DESK_DEPTH  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [DIM_W-1:0]   min_width;
    logic [DIM_W-1:0]   min_height;
    logic [DIM_W-1:0]   desk_width;
    logic [DIM_W-1:0]   desk_height;
    logic [DEPTH_W-1:0] desk_depth;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [AREA_W-1:0] a;
    logic [DIM_W-1:0]  b;
  } mul_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_AREA,
    S_DA,
    S_DB,
    S_DN,
    S_RD,
    S_EA,
    S_CMP,
    S_EB,
    S_ED,
    S_EF,
    S_EG,
    S_PLACE,
    S_SH_RD,
    S_SH_WR,
    S_INS,
    S_FIN,
    S_EM_RD,
    S_EM_WAIT,
    S_EM_EMPTY
  } state_e;

endpackage

[src/dmtr_if.sv]
// Valid/ready channels of the display mode ranker: offered modes in, ranked picks out.
// Depends on dmtr_pkg for field widths.
interface dmtr_offer_if import dmtr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DIM_W-1:0]   offer_width;
  logic [DIM_W-1:0]   offer_height;
  logic [DEPTH_W-1:0] offer_depth;
  logic               final_offer;

  modport source (output valid, offer_width, offer_height, offer_depth, final_offer,
                  input ready);
  modport sink   (input valid, offer_width, offer_height, offer_depth, final_offer,
                  output ready);
endinterface

interface dmtr_pick_if import dmtr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIM_W-1:0]  pick_width;
  logic [DIM_W-1:0]  pick_height;
  logic [RANK_W-1:0] pick_rank;
  logic              list_empty;
  logic              last_pick;

  modport source (output valid, pick_width, pick_height, pick_rank, list_empty, last_pick,
                  input ready);
  modport sink   (input valid, pick_width, pick_height, pick_rank, list_empty, last_pick,
                  output ready);
endinterface

[src/dmtr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dmtr_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 8
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

[src/dmtr_mul.sv]
// Shared 28x14 multiplier with a registered product.
// Depends on dmtr_pkg for widths and the request struct.
module dmtr_mul import dmtr_pkg::*; (
  input  logic              clk_i,
  input  mul_req_t          req_i,
  output logic [PROD_W-1:0] prod_o
);
  logic [PROD_W-1:0] prod_d, prod_q;

  assign prod_d = req_i.a * req_i.b;

  // Hold the product until the next request
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;
endmodule

[src/dmtr_cfg.sv]
// APB register file for the qualification limits and the desktop mode.
// Depends on dmtr_pkg for the register map and cfg_t.
module dmtr_cfg import dmtr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);
  cfg_t     cfg_q;
  cfg_reg_e reg_sel;
  logic     wr_en;

  assign reg_sel = cfg_reg_e'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Update the addressed register on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_width   <= RST_MIN_WIDTH;
      cfg_q.min_height  <= RST_MIN_HEIGHT;
      cfg_q.desk_width  <= RST_DESK_WIDTH;
      cfg_q.desk_height <= RST_DESK_HEIGHT;
      cfg_q.desk_depth  <= RST_DESK_DEPTH;
    end else if (wr_en) begin
      case (reg_sel)
        REG_MIN_WIDTH:   cfg_q.min_width   <= pwdata[DIM_W-1:0];
        REG_MIN_HEIGHT:  cfg_q.min_height  <= pwdata[DIM_W-1:0];
        REG_DESK_WIDTH:  cfg_q.desk_width  <= pwdata[DIM_W-1:0];
        REG_DESK_HEIGHT: cfg_q.desk_height <= pwdata[DIM_W-1:0];
        REG_DESK_DEPTH:  cfg_q.desk_depth  <= pwdata[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_sel)
      REG_MIN_WIDTH:   prdata = APB_DW'(cfg_q.min_width);
      REG_MIN_HEIGHT:  prdata = APB_DW'(cfg_q.min_height);
      REG_DESK_WIDTH:  prdata = APB_DW'(cfg_q.desk_width);
      REG_DESK_HEIGHT: prdata = APB_DW'(cfg_q.desk_height);
      REG_DESK_DEPTH:  prdata = APB_DW'(cfg_q.desk_depth);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;
endmodule

[src/display_mode_topk_ranker_core.sv]
// Display mode ranker: one shared multiplier and an entry RAM under a sequencer.
// Per qualified offer: accept and set up, scan each entry (with more multiplies on an area
// tie), shift entries down one by one, then place, insert and finish; unqualified goes to finish.
// A final offer then emits each list entry (the RAM read plus the result).
// One offer at a time; the multiplier is the limiting unit. Reset empties the list.
`include "display_mode_topk_ranker_core_assert.svh"
module display_mode_topk_ranker_core import dmtr_pkg::*; #(
  parameter int MAX_ENTRIES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  dmtr_offer_if.sink        offer_i,
  dmtr_pick_if.source       pick_o
);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MaxCnt  = CW'(MAX_ENTRIES);
  localparam logic [CW-1:0] LastIdx = CW'(MAX_ENTRIES - 1);

  cfg_t cfg;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] j_q, j_d;
  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] j_inc, k_dec;

  logic [DIM_W-1:0]  w_q, w_d, h_q, h_d;
  logic              fin_q, fin_d;
  logic [AREA_W-1:0] area_q, area_d;
  logic [AREA_W-1:0] dn_q, dn_d;
  logic [AREA_W-1:0] acc_q, acc_d;
  logic [PROD_W-1:0] t_q, t_d;

  mul_req_t          mul_req;
  logic [PROD_W-1:0] prod;
  logic [AREA_W-1:0] prod_lo;
  logic [AREA_W-1:0] diff_abs;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [AREA_W-1:0] ram_wdata, ram_rdata;
  logic [DIM_W-1:0]  rd_w, rd_h;

  logic qual;
  logic emit_last;

  dmtr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dmtr_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  dmtr_ram #(
    .WIDTH (AREA_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_w      = ram_rdata[AREA_W-1:DIM_W];
  assign rd_h      = ram_rdata[DIM_W-1:0];
  assign prod_lo   = prod[AREA_W-1:0];
  assign diff_abs  = (acc_q >= prod_lo) ? (acc_q - prod_lo) : (prod_lo - acc_q);
  assign j_inc     = j_q + 1'b1;
  assign k_dec     = k_q - 1'b1;
  assign emit_last = (j_inc == cnt_q);

  assign qual = (offer_i.offer_depth == cfg.desk_depth) &&
                (offer_i.offer_width >= cfg.min_width) &&
                (offer_i.offer_height >= cfg.min_height);

  // Result port: entry from the RAM read register, or the empty-list marker
  assign offer_i.ready      = (state_q == S_IDLE);
  assign pick_o.valid       = (state_q == S_EM_WAIT) || (state_q == S_EM_EMPTY);
  assign pick_o.pick_width  = (state_q == S_EM_WAIT) ? rd_w : '0;
  assign pick_o.pick_height = (state_q == S_EM_WAIT) ? rd_h : '0;
  assign pick_o.pick_rank   = (state_q == S_EM_WAIT) ? RANK_W'(j_q) : '0;
  assign pick_o.list_empty  = (state_q == S_EM_EMPTY);
  assign pick_o.last_pick   = (state_q == S_EM_EMPTY) || emit_last;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    h_q    <= h_d;
    fin_q  <= fin_d;
    area_q <= area_d;
    dn_q   <= dn_d;
    acc_q  <= acc_d;
    t_q    <= t_d;
  end

  // Sequencer: qualify, scan, shift, insert, emit
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    j_d       = j_q;
    k_d       = k_q;
    w_d       = w_q;
    h_d       = h_q;
    fin_d     = fin_q;
    area_d    = area_q;
    dn_d      = dn_q;
    acc_d     = acc_q;
    t_d       = t_q;
    mul_req   = '0;
    ram_we    = 1'b0;
    ram_waddr = j_q[AW-1:0];
    ram_wdata = {w_q, h_q};
    ram_re    = 1'b0;
    ram_raddr = j_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (offer_i.valid) begin
          w_d     = offer_i.offer_width;
          h_d     = offer_i.offer_height;
          fin_d   = offer_i.final_offer;
          state_d = qual ? S_AREA : S_FIN;
        end
      end
      // Offer area
      S_AREA: begin
        mul_req = '{en: 1'b1, a: AREA_W'(w_q), b: h_q};
        state_d = S_DA;
      end
      S_DA: begin
        area_d  = prod_lo;
        mul_req = '{en: 1'b1, a: AREA_W'(w_q), b: cfg.desk_height};
        state_d = S_DB;
      end
      S_DB: begin
        acc_d   = prod_lo;
        mul_req = '{en: 1'b1, a: AREA_W'(cfg.desk_width), b: h_q};
        state_d = S_DN;
      end
      // Offer aspect distance, then start the scan
      S_DN: begin
        dn_d    = diff_abs;
        j_d     = '0;
        state_d = (cnt_q == '0) ? S_PLACE : S_RD;
      end
      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_EA;
      end
      S_EA: begin
        mul_req = '{en: 1'b1, a: AREA_W'(rd_w), b: rd_h};
        state_d = S_CMP;
      end
      // Compare areas; drop duplicates, stop on smaller area, resolve ties below
      S_CMP: begin
        if (rd_w == w_q && rd_h == h_q) begin
          state_d = S_FIN;
        end else if (area_q < prod_lo) begin
          state_d = S_PLACE;
        end else if (area_q == prod_lo) begin
          mul_req = '{en: 1'b1, a: AREA_W'(rd_w), b: cfg.desk_height};
          state_d = S_EB;
        end else begin
          j_d     = j_inc;
          state_d = (j_inc == cnt_q) ? S_PLACE : S_RD;
        end
      end
      S_EB: begin
        acc_d   = prod_lo;
        mul_req = '{en: 1'b1, a: AREA_W'(cfg.desk_width), b: rd_h};
        state_d = S_ED;
      end
      S_ED: begin
        acc_d   = diff_abs;
        mul_req = '{en: 1'b1, a: dn_q, b: rd_h};
        state_d = S_EF;
      end
      S_EF: begin
        t_d     = prod;
        mul_req = '{en: 1'b1, a: acc_q, b: h_q};
        state_d = S_EG;
      end
      // Tie on area: closer aspect ratio ranks first
      S_EG: begin
        if (t_q < prod) begin
          state_d = S_PLACE;
        end else begin
          j_d     = j_inc;
          state_d = (j_inc == cnt_q) ? S_PLACE : S_RD;
        end
      end
      // Decide drop or insert; grow the list unless full
      S_PLACE: begin
        if (cnt_q == MaxCnt) begin
          if (j_q == MaxCnt) begin
            state_d = S_FIN;
          end else begin
            k_d     = LastIdx;
            state_d = (LastIdx > j_q) ? S_SH_RD : S_INS;
          end
        end else begin
          cnt_d   = cnt_q + 1'b1;
          k_d     = cnt_q;
          state_d = (cnt_q > j_q) ? S_SH_RD : S_INS;
        end
      end
      // Shift entries down one slot, from the tail toward the insert point
      S_SH_RD: begin
        ram_re    = 1'b1;
        ram_raddr = k_dec[AW-1:0];
        state_d   = S_SH_WR;
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = k_q[AW-1:0];
        ram_wdata = ram_rdata;
        k_d       = k_dec;
        state_d   = (k_dec > j_q) ? S_SH_RD : S_INS;
      end
      S_INS: begin
        ram_we  = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        j_d = '0;
        if (fin_q) begin
          state_d = (cnt_q == '0) ? S_EM_EMPTY : S_EM_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      // Emit the list in rank order, then clear it
      S_EM_RD: begin
        ram_re  = 1'b1;
        state_d = S_EM_WAIT;
      end
      S_EM_WAIT: begin
        if (pick_o.ready) begin
          if (emit_last) begin
            cnt_d   = '0;
            state_d = S_IDLE;
          end else begin
            j_d     = j_inc;
            state_d = S_EM_RD;
          end
        end
      end
      S_EM_EMPTY: begin
        if (pick_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `DMTR_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= MaxCnt)
  `DMTR_ASSERT(a_no_overlap, !(offer_i.ready && pick_o.valid))
  `DMTR_ASSERT(a_clear_after_emit, (pick_o.valid && pick_o.ready && pick_o.last_pick) |=> (cnt_q == '0))
  `DMTR_ASSERT(a_insert_in_range, (state_q == S_INS) |-> (j_q < MaxCnt))
endmodule

[tb/display_mode_topk_ranker_core_tb.sv]
// Testbench for display_mode_topk_ranker_core: directed table, then random mode lists.
// Needs dmtr_pkg, the dmtr_offer_if/dmtr_pick_if interfaces and the core RTL.
module display_mode_topk_ranker_core_tb;
  import dmtr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 8;
  localparam int MAX_PICKS  = 8;
  localparam int SETTLE_CYC = 150;
  localparam int LIMIT_CYC  = 400000;

  typedef struct packed {
    logic [DIM_W-1:0]   offer_width;
    logic [DIM_W-1:0]   offer_height;
    logic [DEPTH_W-1:0] offer_depth;
    logic               final_offer;
  } offer_t;

  typedef struct packed {
    logic [DIM_W-1:0]  pick_width;
    logic [DIM_W-1:0]  pick_height;
    logic [RANK_W-1:0] pick_rank;
    logic              list_empty;
    logic              last_pick;
  } pick_t;

  typedef struct packed {
    offer_t req;
    logic   typed;
    pick_t  want;
  } dir_row_t;

  localparam pick_t NO_PICK    = '0;
  localparam pick_t EMPTY_PICK = '{14'd0, 14'd0, 3'd0, 1'b1, 1'b1};

  // Directed requests under the reset configuration; typed rows carry the one pick due
  localparam int DIR_N = 24;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{'{14'd0,     14'd0,     6'd0,  1'b1}, 1'b1, EMPTY_PICK},
    '{'{14'd640,   14'd480,   6'd32, 1'b1}, 1'b1, '{14'd640, 14'd480, 3'd0, 1'b0, 1'b1}},
    '{'{14'd16383, 14'd16383, 6'd32, 1'b1}, 1'b1, '{14'd16383, 14'd16383, 3'd0, 1'b0, 1'b1}},
    '{'{14'd639,   14'd480,   6'd32, 1'b0}, 1'b0, NO_PICK},
    '{'{14'd640,   14'd479,   6'd32, 1'b0}, 1'b0, NO_PICK},
    '{'{14'd1920,  14'd1080,  6'd31, 1'b0}, 1'b0, NO_PICK},
    '{'{14'd1920,  14'd1080,  6'd63, 1'b0}, 1'b0, NO_PICK},
    '{'{14'd1920,  14'd1080,  6'd32, 1'b0}, 1'b0, NO_PICK},
    '{'{14'd1920,  14'd1080,  6'd32, 1'b0}, 1'b0, NO_PICK},
    '{'{14'd1600,  14'd900,   6'd32, 1'b0}, 1'b0, NO_PICK},
    '{'{14'd1200,  14'd1200,  6'd32, 1'b0}, 1'b0, NO_PICK},
    '{'{14'd1800,  14'd800,   6'd32, 1'b0}, 1'b0, NO_PICK},
    '{'{14'd1280,  14'd720,   6'd32, 1'b0}, 1'b0, NO_PICK},
    '{'{14'd1024,  14'd768,   6'd32, 1'b0}, 1'b0, NO_PICK},
    '{'{14'd2560,  14'd1440,  6'd32, 1'b0}, 1'b0, NO_PICK},
    '{'{14'd3840,  14'd2160,  6'd32, 1'b0}, 1'b0, NO_PICK},
    '{'{14'd16383, 14'd16383, 6'd32, 1'b0}, 1'b0, NO_PICK},
    '{'{14'd640,   14'd480,   6'd32, 1'b0}, 1'b0, NO_PICK},
    '{'{14'd1280,  14'd720,   6'd32, 1'b0}, 1'b0, NO_PICK},
    '{'{14'd800,   14'd600,   6'd32, 1'b1}, 1'b0, NO_PICK},
    '{'{14'd0,     14'd16383, 6'd32, 1'b1}, 1'b1, EMPTY_PICK},
    '{'{14'd16383, 14'd0,     6'd32, 1'b1}, 1'b1, EMPTY_PICK},
    '{'{14'd16383, 14'd16383, 6'd32, 1'b0}, 1'b0, NO_PICK},
    '{'{14'd16383, 14'd16383, 6'd0,  1'b1}, 1'b1, '{14'd16383, 14'd16383, 3'd0, 1'b0, 1'b1}}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  dmtr_offer_if ofr_if ();
  dmtr_pick_if  pck_if ();

  display_mode_topk_ranker_core #(
    .MAX_ENTRIES(MAX_PICKS)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .offer_i(ofr_if),
    .pick_o (pck_if)
  );

  // Mirror of the ranked list and the configuration
  cfg_t             cfg_now;
  logic [DIM_W-1:0] list_w [MAX_PICKS];
  logic [DIM_W-1:0] list_h [MAX_PICKS];
  int               list_len;
  pick_t            picks_due [$];
  int               err_cnt;
  int               cycle_cnt = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Hold both sides busy during a recurring window of cycle_cnt
  function automatic bit no_idle();
    return (cycle_cnt % 4000) >= 2800;
  endfunction

  function automatic bit mode_passes(offer_t o);
    return o.offer_depth == cfg_now.desk_depth && o.offer_width >= cfg_now.min_width &&
           o.offer_height >= cfg_now.min_height;
  endfunction

  // |w*H - W*h|: aspect distance to the desktop, multiplied out
  function automatic logic [63:0] aspect_gap(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    logic [63:0] a;
    logic [63:0] b;
    a = 64'(w) * 64'(cfg_now.desk_height);
    b = 64'(cfg_now.desk_width) * 64'(h);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Insert one qualified mode into the sorted list
  function automatic void insert_mode(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    logic [63:0] area;
    logic [63:0] gap;
    logic [63:0] ent_area;
    int j;
    area = 64'(w) * 64'(h);
    gap  = aspect_gap(w, h);
    for (j = 0; j < list_len; j++) begin
      ent_area = 64'(list_w[j]) * 64'(list_h[j]);
      if (list_w[j] == w && list_h[j] == h) break;
      if (area < ent_area) break;
      if (area == ent_area && gap * 64'(list_h[j]) < aspect_gap(list_w[j], list_h[j]) * 64'(h))
        break;
    end
    // drop duplicates
    if (j < list_len && list_w[j] == w && list_h[j] == h) return;
    if (list_len >= MAX_PICKS) begin
      if (j >= MAX_PICKS) return;
    end else begin
      list_len++;
    end
    for (int k = list_len - 1; k > j; k--) begin
      list_w[k] = list_w[k-1];
      list_h[k] = list_h[k-1];
    end
    list_w[j] = w;
    list_h[j] = h;
  endfunction

  // Rank one request; on a final request emit the list and clear it
  function automatic void rank_offer(offer_t o, ref pick_t res [$]);
    if (mode_passes(o)) insert_mode(o.offer_width, o.offer_height);
    if (!o.final_offer) return;
    if (list_len == 0) begin
      res.push_back(EMPTY_PICK);
    end else begin
      for (int i = 0; i < list_len; i++)
        res.push_back('{list_w[i], list_h[i], RANK_W'(i), 1'b0, (i == list_len - 1)});
    end
    list_len = 0;
  endfunction

  task automatic send_offer(input offer_t o, input bit typed, input pick_t want);
    pick_t res [$];
    while (!no_idle() && $urandom_range(0, 99) < 34) begin
      ofr_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    ofr_if.valid        <= 1'b1;
    ofr_if.offer_width  <= o.offer_width;
    ofr_if.offer_height <= o.offer_height;
    ofr_if.offer_depth  <= o.offer_depth;
    ofr_if.final_offer  <= o.final_offer;
    @(posedge clk_i);
    while (!ofr_if.ready) @(posedge clk_i);
    rank_offer(o, res);
    if (typed) picks_due.push_back(want);
    else foreach (res[i]) picks_due.push_back(res[i]);
  endtask

  // Wait out all picks, then the tail of any request still in flight
  task automatic settle();
    ofr_if.valid <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic reg_write(input cfg_reg_e idx, input logic [APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MIN_WIDTH:   cfg_now.min_width   = val[DIM_W-1:0];
      REG_MIN_HEIGHT:  cfg_now.min_height  = val[DIM_W-1:0];
      REG_DESK_WIDTH:  cfg_now.desk_width  = val[DIM_W-1:0];
      REG_DESK_HEIGHT: cfg_now.desk_height = val[DIM_W-1:0];
      REG_DESK_DEPTH:  cfg_now.desk_depth  = val[DEPTH_W-1:0];
      default: ;
    endcase
  endtask

  // One configuration, then random mode lists until enough qualified requests went in
  task automatic run_phase(input cfg_t c, input int lo, input int hi, input int quota);
    logic [DIM_W-1:0] pool_w [4];
    logic [DIM_W-1:0] pool_h [4];
    offer_t o;
    int qual;
    int len;
    int s;
    bit noisy;
    settle();
    reg_write(REG_MIN_WIDTH,   32'(c.min_width));
    reg_write(REG_MIN_HEIGHT,  32'(c.min_height));
    reg_write(REG_DESK_WIDTH,  32'(c.desk_width));
    reg_write(REG_DESK_HEIGHT, 32'(c.desk_height));
    reg_write(REG_DESK_DEPTH,  32'(c.desk_depth));
    for (int p = 0; p < 4; p++) begin
      pool_w[p] = DIM_W'($urandom_range(hi, lo));
      pool_h[p] = DIM_W'($urandom_range(hi, lo));
    end
    qual = 0;
    while (qual < quota) begin
      len   = $urandom_range(1, 12);
      noisy = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < len; i++) begin
        o.final_offer = (i == len - 1) ? (noisy ? 1'($urandom_range(0, 1)) : 1'b1) : 1'b0;
        if (noisy || $urandom_range(0, 99) < 12) begin
          // noise over the full field ranges
          o.offer_width  = DIM_W'($urandom_range(0, 16383));
          o.offer_height = DIM_W'($urandom_range(0, 16383));
          o.offer_depth  = DEPTH_W'($urandom_range(0, 63));
        end else begin
          s = $urandom_range(0, 3);
          if ($urandom_range(0, 3) != 0) begin
            pool_w[s] = DIM_W'($urandom_range(hi, lo));
            pool_h[s] = DIM_W'($urandom_range(hi, lo));
          end
          o.offer_width  = pool_w[s];
          o.offer_height = pool_h[s];
          o.offer_depth  = c.desk_depth;
        end
        if (mode_passes(o)) qual++;
        send_offer(o, 1'b0, NO_PICK);
      end
    end
  endtask

  task automatic cmp_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // Check each accepted pick against the oldest one due; advance the ready pattern
  always @(posedge clk_i) begin
    pick_t want;
    if (rst_ni && pck_if.valid && pck_if.ready) begin
      if (picks_due.size() == 0) begin
        $error("pick with none due: width %0d height %0d rank %0d",
               pck_if.pick_width, pck_if.pick_height, pck_if.pick_rank);
        err_cnt++;
      end else begin
        want = picks_due.pop_front();
        cmp_field("pick_width",  int'(want.pick_width),  int'(pck_if.pick_width));
        cmp_field("pick_height", int'(want.pick_height), int'(pck_if.pick_height));
        cmp_field("pick_rank",   int'(want.pick_rank),   int'(pck_if.pick_rank));
        cmp_field("list_empty",  int'(want.list_empty),  int'(pck_if.list_empty));
        cmp_field("last_pick",   int'(want.last_pick),   int'(pck_if.last_pick));
      end
    end
    pck_if.ready <= rst_ni && (no_idle() || $urandom_range(0, 99) >= 34);
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYC) begin
      $display("[display_mode_topk_ranker_core] ERROR");
      $finish;
    end
  end

  initial begin
    err_cnt             = 0;
    list_len            = 0;
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    ofr_if.valid        = 1'b0;
    ofr_if.offer_width  = '0;
    ofr_if.offer_height = '0;
    ofr_if.offer_depth  = '0;
    ofr_if.final_offer  = 1'b0;
    cfg_now = '{RST_MIN_WIDTH, RST_MIN_HEIGHT, RST_DESK_WIDTH, RST_DESK_HEIGHT, RST_DESK_DEPTH};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table under the reset configuration
    for (int i = 0; i < DIR_N; i++)
      send_offer(DIR_TAB[i].req, DIR_TAB[i].typed, DIR_TAB[i].want);

    // Small sizes with zero dimensions and many area ties
    run_phase('{14'd0, 14'd0, 14'd16, 14'd9, 6'd0}, 0, 40, 45);
    // Upper range of sizes, extreme aspect reference, top depth
    run_phase('{14'd8000, 14'd8000, 14'd16383, 14'd1, 6'd63}, 8000, 16383, 35);
    // Zero desktop height
    run_phase('{14'd0, 14'd0, 14'd1, 14'd0, 6'd24}, 0, 12, 35);
    // Mid range, 4:3 desktop
    run_phase('{14'd100, 14'd50, 14'd4, 14'd3, 6'd32}, 60, 2000, 55);
    // Only the largest mode qualifies
    run_phase('{14'd16383, 14'd16383, 14'd16383, 14'd16383, 6'd16}, 16383, 16383, 6);

    settle();
    if (err_cnt == 0) begin
      $display("[display_mode_topk_ranker_core] OK");
    end else begin
      $display("[display_mode_topk_ranker_core] ERROR");
    end
    $finish;
  end

endmodule
